[hw/rtl/cxlz_pkg.sv]
`default_nettype none

package cxlz_pkg;

    localparam int HIST_AW    = 16;
    localparam int HIST_DEPTH = 1 << HIST_AW;
    localparam int OUT_LANES  = 8;
    localparam int LANE_AW    = $clog2(OUT_LANES);

    localparam logic [2:0]  HDR_MASK   = 3'h7;
    localparam logic [2:0]  HDR_MIN    = 3'd3;
    localparam logic [9:0]  END_LENGTH = 10'h102;
    localparam logic [16:0] LIMIT_RST  = 17'h10000;
    localparam logic [16:0] HIST_SPAN  = 17'(HIST_DEPTH);

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_END       = 3'd1,
        ST_BAD_HDR   = 3'd2,
        ST_BAD_OFF   = 3'd3,
        ST_OVERFLOW  = 3'd4,
        ST_TRUNCATED = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        PH_HEADER,
        PH_TAG1,
        PH_LIT,
        PH_TAG2,
        PH_LEN_UNARY,
        PH_LEN_VALUE,
        PH_EXT_TAG,
        PH_OFF_UNARY,
        PH_OFF_VALUE,
        PH_OFF_LOW,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        CT_IDLE,
        CT_DECODE,
        CT_COPY_RD,
        CT_COPY_WR,
        CT_FINISH
    } ctl_t;

endpackage

`default_nettype wire

[hw/rtl/cxlz_stream_if.sv]
`default_nettype none

interface cxlz_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface cxlz_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] out_bytes;
    logic [3:0]  byte_count;
    logic [2:0]  status;
    logic        last_of_run;

    modport source (output valid, output out_bytes, output byte_count, output status,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_bytes, input byte_count, input status,
                    input last_of_run, output ready);
endinterface

`default_nettype wire

[hw/rtl/cxlz_ram.sv]
`default_nettype none

module cxlz_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/cx_lz_bitstream_decompressor.sv]
`default_nettype none

// channel  | dir | payload                                        | item
// in_ch    | in  | in_byte[7:0], end_of_input                     | one compressed byte
// out_ch   | out | out_bytes[63:0], byte_count, status, last_of_run | up to eight bytes
// cfg      | in  | cfg_we, cfg_wdata[16:0] (output_limit)         | register write
//
// one byte is taken at a time; the bit parser walks its tokens step by step, a literal
// is written in a single step, and each copied byte is read from history, then written
// (CT_COPY_RD, then CT_COPY_WR); a full group of eight still held at the end of a byte
// goes out before the final status of that byte
// the final result of a byte is placed in the output register before the next byte is taken
// reset clears all control state; the history memory holds no reset and is only read
// where written; a stalled out_ch holds the parser while a full group of eight waits

module cx_lz_bitstream_decompressor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    cxlz_in_if.sink          in_ch,
    cxlz_out_if.source       out_ch,
    input  wire logic        cfg_we,
    input  wire logic [16:0] cfg_wdata
);

    // control and parser state
    cxlz_pkg::ctl_t    ctl_reg, ctl_next;
    cxlz_pkg::phase_t  phase_reg, phase_next;
    cxlz_pkg::status_t done_st_reg, done_st_next;
    cxlz_pkg::status_t fin_st_reg, fin_st_next;
    logic              fin_has_reg, fin_has_next;
    logic              last_in_reg, last_in_next;
    logic [23:0]       buf_reg, buf_next;
    logic [4:0]        held_reg, held_next;
    logic [16:0]       count_reg, count_next;
    logic [8:0]        len_reg, len_next;
    logic [8:0]        poff_reg, poff_next;
    logic [3:0]        uw_reg, uw_next;
    logic [16:0]       dist_reg, dist_next;
    logic [8:0]        rem_reg, rem_next;
    logic [16:0]       limit_reg;

    // packing of produced bytes
    logic [63:0]                       acc_reg, acc_next;
    logic [cxlz_pkg::LANE_AW-1:0]      lanes_reg, lanes_next;
    logic                              full_reg, full_next;
    logic                              emitted_reg, emitted_next;

    // output register
    logic        ov_reg, ov_next;
    logic [63:0] obytes_reg, obytes_next;
    logic [3:0]  ocnt_reg, ocnt_next;
    logic [2:0]  ost_reg, ost_next;
    logic        olast_reg, olast_next;

    logic                          out_free;
    logic                          in_fire;
    logic                          put_en;
    logic [7:0]                    put_val;
    logic                          ram_re;
    logic [cxlz_pkg::HIST_AW-1:0]  ram_raddr;
    logic [7:0]                    ram_rdata;
    logic [16:0]                   src_addr;

    assign out_free = !ov_reg || out_ch.ready;
    assign in_fire  = in_ch.valid && in_ch.ready;
    assign src_addr = count_reg - dist_reg;

    cxlz_ram #(
        .WIDTH (8),
        .DEPTH (cxlz_pkg::HIST_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (put_en),
        .waddr (count_reg[cxlz_pkg::HIST_AW-1:0]),
        .wdata (put_val),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // handshake and history read control
    always_comb
    begin
        in_ch.ready = (ctl_reg == cxlz_pkg::CT_IDLE);
        ram_re      = (ctl_reg == cxlz_pkg::CT_COPY_RD);
        ram_raddr   = src_addr[cxlz_pkg::HIST_AW-1:0];
    end

    assign out_ch.valid       = ov_reg;
    assign out_ch.out_bytes   = obytes_reg;
    assign out_ch.byte_count  = ocnt_reg;
    assign out_ch.status      = ost_reg;
    assign out_ch.last_of_run = olast_reg;

    // next-state logic
    always_comb
    begin
        logic        want_put;
        logic        stall;
        logic        at_eob;
        logic [3:0]  nbits;
        logic [8:0]  vmask;
        logic [9:0]  vsum;
        logic [16:0] off;
        logic [17:0] reach;
        logic [3:0]  uw_inc;

        ctl_next     = ctl_reg;
        phase_next   = phase_reg;
        done_st_next = done_st_reg;
        fin_st_next  = fin_st_reg;
        fin_has_next = fin_has_reg;
        last_in_next = last_in_reg;
        buf_next     = buf_reg;
        held_next    = held_reg;
        count_next   = count_reg;
        len_next     = len_reg;
        poff_next    = poff_reg;
        uw_next      = uw_reg;
        dist_next    = dist_reg;
        rem_next     = rem_reg;
        acc_next     = acc_reg;
        lanes_next   = lanes_reg;
        full_next    = full_reg;
        emitted_next = emitted_reg;
        ov_next      = ov_reg && !out_ch.ready;
        obytes_next  = obytes_reg;
        ocnt_next    = ocnt_reg;
        ost_next     = ost_reg;
        olast_next   = olast_reg;
        put_en       = 1'b0;
        put_val      = 8'd0;
        want_put     = 1'b0;
        stall        = 1'b0;
        at_eob       = 1'b0;
        nbits        = (uw_reg == 4'd0) ? 4'd1 : ((uw_reg > 4'd8) ? 4'd8 : uw_reg);
        vmask        = 9'((10'd1 << nbits) - 10'd1);
        vsum         = {1'b0, vmask} + {1'b0, buf_reg[8:0] & vmask};
        off          = {poff_reg, buf_reg[7:0]};
        reach        = {1'b0, count_reg} + {9'd0, len_reg};
        uw_inc       = uw_reg + 4'd1;

        unique case (ctl_reg)
            cxlz_pkg::CT_IDLE:
            begin
                if (in_fire)
                begin
                    last_in_next = in_ch.end_of_input;
                    acc_next     = 64'd0;
                    lanes_next   = '0;
                    full_next    = 1'b0;
                    emitted_next = 1'b0;
                    if (phase_reg == cxlz_pkg::PH_DONE)
                    begin
                        fin_st_next  = done_st_reg;
                        fin_has_next = 1'b1;
                        ctl_next     = cxlz_pkg::CT_FINISH;
                    end
                    else if (phase_reg == cxlz_pkg::PH_HEADER)
                    begin
                        if ((in_ch.in_byte[2:0] & cxlz_pkg::HDR_MASK) <= cxlz_pkg::HDR_MIN)
                        begin
                            fin_st_next  = cxlz_pkg::ST_BAD_HDR;
                            fin_has_next = 1'b1;
                            ctl_next     = cxlz_pkg::CT_FINISH;
                        end
                        else
                        begin
                            buf_next   = {19'd0, in_ch.in_byte[7:3]};
                            held_next  = 5'd5;
                            phase_next = cxlz_pkg::PH_TAG1;
                            ctl_next   = cxlz_pkg::CT_DECODE;
                        end
                    end
                    else
                    begin
                        buf_next  = buf_reg | ({16'd0, in_ch.in_byte} << held_reg);
                        held_next = held_reg + 5'd8;
                        ctl_next  = cxlz_pkg::CT_DECODE;
                    end
                end
            end

            cxlz_pkg::CT_DECODE:
            begin
                unique case (phase_reg)
                    cxlz_pkg::PH_TAG1:
                    begin
                        if (held_reg == 5'd0)
                        begin
                            at_eob = 1'b1;
                        end
                        else
                        begin
                            phase_next = buf_reg[0] ? cxlz_pkg::PH_TAG2 : cxlz_pkg::PH_LIT;
                            buf_next   = buf_reg >> 1;
                            held_next  = held_reg - 5'd1;
                        end
                    end
                    cxlz_pkg::PH_LIT:
                    begin
                        if (held_reg < 5'd8)
                        begin
                            at_eob = 1'b1;
                        end
                        else if (count_reg >= limit_reg)
                        begin
                            fin_st_next  = cxlz_pkg::ST_OVERFLOW;
                            fin_has_next = 1'b1;
                            ctl_next     = cxlz_pkg::CT_FINISH;
                        end
                        else if (full_reg && !out_free)
                        begin
                            stall = 1'b1;
                        end
                        else
                        begin
                            want_put   = 1'b1;
                            put_val    = buf_reg[7:0];
                            buf_next   = buf_reg >> 8;
                            held_next  = held_reg - 5'd8;
                            phase_next = cxlz_pkg::PH_TAG1;
                        end
                    end
                    cxlz_pkg::PH_TAG2:
                    begin
                        if (held_reg == 5'd0)
                        begin
                            at_eob = 1'b1;
                        end
                        else
                        begin
                            poff_next = 9'd0;
                            buf_next  = buf_reg >> 1;
                            held_next = held_reg - 5'd1;
                            if (buf_reg[0])
                            begin
                                len_next   = 9'd2;
                                phase_next = cxlz_pkg::PH_OFF_LOW;
                            end
                            else
                            begin
                                uw_next    = 4'd0;
                                phase_next = cxlz_pkg::PH_LEN_UNARY;
                            end
                        end
                    end
                    cxlz_pkg::PH_LEN_UNARY, cxlz_pkg::PH_OFF_UNARY:
                    begin
                        if (held_reg == 5'd0)
                        begin
                            at_eob = 1'b1;
                        end
                        else
                        begin
                            buf_next  = buf_reg >> 1;
                            held_next = held_reg - 5'd1;
                            uw_next   = uw_inc;
                            if (buf_reg[0])
                            begin
                                phase_next = (phase_reg == cxlz_pkg::PH_LEN_UNARY)
                                           ? cxlz_pkg::PH_LEN_VALUE : cxlz_pkg::PH_OFF_VALUE;
                            end
                            else if (uw_inc >= 4'd8)
                            begin
                                fin_st_next  = (phase_reg == cxlz_pkg::PH_LEN_UNARY)
                                             ? cxlz_pkg::ST_END : cxlz_pkg::ST_BAD_OFF;
                                fin_has_next = 1'b1;
                                ctl_next     = cxlz_pkg::CT_FINISH;
                            end
                        end
                    end
                    cxlz_pkg::PH_LEN_VALUE, cxlz_pkg::PH_OFF_VALUE:
                    begin
                        if (held_reg < {1'b0, nbits})
                        begin
                            at_eob = 1'b1;
                        end
                        else
                        begin
                            buf_next  = buf_reg >> nbits;
                            held_next = held_reg - {1'b0, nbits};
                            if (phase_reg == cxlz_pkg::PH_LEN_VALUE)
                            begin
                                if (vsum + 10'd2 >= cxlz_pkg::END_LENGTH)
                                begin
                                    fin_st_next  = cxlz_pkg::ST_END;
                                    fin_has_next = 1'b1;
                                    ctl_next     = cxlz_pkg::CT_FINISH;
                                end
                                else
                                begin
                                    len_next   = 9'(vsum + 10'd2);
                                    phase_next = cxlz_pkg::PH_EXT_TAG;
                                end
                            end
                            else
                            begin
                                poff_next  = vsum[8:0];
                                phase_next = cxlz_pkg::PH_OFF_LOW;
                            end
                        end
                    end
                    cxlz_pkg::PH_EXT_TAG:
                    begin
                        if (held_reg == 5'd0)
                        begin
                            at_eob = 1'b1;
                        end
                        else
                        begin
                            buf_next  = buf_reg >> 1;
                            held_next = held_reg - 5'd1;
                            if (buf_reg[0])
                            begin
                                phase_next = cxlz_pkg::PH_OFF_LOW;
                            end
                            else
                            begin
                                uw_next    = 4'd0;
                                phase_next = cxlz_pkg::PH_OFF_UNARY;
                            end
                        end
                    end
                    cxlz_pkg::PH_OFF_LOW:
                    begin
                        if (held_reg < 5'd8)
                        begin
                            at_eob = 1'b1;
                        end
                        else if (off == 17'd0 || off > count_reg || off > cxlz_pkg::HIST_SPAN)
                        begin
                            fin_st_next  = cxlz_pkg::ST_BAD_OFF;
                            fin_has_next = 1'b1;
                            ctl_next     = cxlz_pkg::CT_FINISH;
                        end
                        else if (reach > {1'b0, limit_reg})
                        begin
                            fin_st_next  = cxlz_pkg::ST_OVERFLOW;
                            fin_has_next = 1'b1;
                            ctl_next     = cxlz_pkg::CT_FINISH;
                        end
                        else
                        begin
                            buf_next   = buf_reg >> 8;
                            held_next  = held_reg - 5'd8;
                            dist_next  = off;
                            rem_next   = len_reg;
                            phase_next = cxlz_pkg::PH_TAG1;
                            ctl_next   = cxlz_pkg::CT_COPY_RD;
                        end
                    end
                    default:
                    begin
                        at_eob = 1'b1;
                    end
                endcase

                // bits ran out before the next token step
                if (at_eob)
                begin
                    ctl_next = cxlz_pkg::CT_FINISH;
                    if (last_in_reg)
                    begin
                        fin_has_next = 1'b1;
                        fin_st_next  = (phase_reg == cxlz_pkg::PH_TAG1 && held_reg == 5'd0)
                                     ? cxlz_pkg::ST_OK : cxlz_pkg::ST_TRUNCATED;
                    end
                    else
                    begin
                        fin_has_next = 1'b0;
                    end
                end
            end

            cxlz_pkg::CT_COPY_RD:
            begin
                ctl_next = cxlz_pkg::CT_COPY_WR;
            end

            cxlz_pkg::CT_COPY_WR:
            begin
                if (full_reg && !out_free)
                begin
                    stall = 1'b1;
                end
                else
                begin
                    want_put = 1'b1;
                    put_val  = ram_rdata;
                    rem_next = rem_reg - 9'd1;
                    ctl_next = (rem_reg == 9'd1) ? cxlz_pkg::CT_DECODE : cxlz_pkg::CT_COPY_RD;
                end
            end

            cxlz_pkg::CT_FINISH:
            begin
                if (out_free)
                begin
                    ov_next     = 1'b1;
                    obytes_next = acc_reg;
                    ocnt_next   = full_reg ? 4'(cxlz_pkg::OUT_LANES) : 4'(lanes_reg);
                    ost_next    = cxlz_pkg::ST_OK;
                    olast_next  = 1'b1;
                    if (full_reg)
                    begin
                        // a full group goes first; a status then follows on its own
                        olast_next = !fin_has_reg;
                        full_next  = 1'b0;
                        acc_next   = 64'd0;
                        lanes_next = '0;
                        if (!fin_has_reg)
                        begin
                            ctl_next = cxlz_pkg::CT_IDLE;
                        end
                    end
                    else
                    begin
                        ctl_next = cxlz_pkg::CT_IDLE;
                        if (fin_has_reg)
                        begin
                            ost_next = fin_st_reg;
                        end
                        else if (lanes_reg == '0 && emitted_reg)
                        begin
                            ov_next = ov_reg && !out_ch.ready;
                        end
                    end
                    if (fin_has_reg && !full_reg)
                    begin
                        phase_next   = cxlz_pkg::PH_DONE;
                        done_st_next = fin_st_reg;
                        buf_next     = 24'd0;
                        held_next    = 5'd0;
                    end
                end
            end

            default:
            begin
                ctl_next = cxlz_pkg::CT_IDLE;
            end
        endcase

        // write one produced byte into history and the packing register
        if (want_put && !stall)
        begin
            put_en     = 1'b1;
            count_next = count_reg + 17'd1;
            if (full_reg)
            begin
                ov_next      = 1'b1;
                obytes_next  = acc_reg;
                ocnt_next    = 4'(cxlz_pkg::OUT_LANES);
                ost_next     = cxlz_pkg::ST_OK;
                olast_next   = 1'b0;
                emitted_next = 1'b1;
                acc_next     = {56'd0, put_val};
                lanes_next   = cxlz_pkg::LANE_AW'(1);
                full_next    = 1'b0;
            end
            else
            begin
                acc_next   = acc_reg | ({56'd0, put_val} << {lanes_reg, 3'b000});
                lanes_next = lanes_reg + cxlz_pkg::LANE_AW'(1);
                full_next  = (lanes_reg == cxlz_pkg::LANE_AW'(cxlz_pkg::OUT_LANES - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg     <= cxlz_pkg::CT_IDLE;
            phase_reg   <= cxlz_pkg::PH_HEADER;
            done_st_reg <= cxlz_pkg::ST_OK;
            fin_st_reg  <= cxlz_pkg::ST_OK;
            fin_has_reg <= 1'b0;
            last_in_reg <= 1'b0;
            buf_reg     <= 24'd0;
            held_reg    <= 5'd0;
            count_reg   <= 17'd0;
            len_reg     <= 9'd0;
            poff_reg    <= 9'd0;
            uw_reg      <= 4'd0;
            rem_reg     <= 9'd0;
            lanes_reg   <= '0;
            full_reg    <= 1'b0;
            emitted_reg <= 1'b0;
            ov_reg      <= 1'b0;
            limit_reg   <= cxlz_pkg::LIMIT_RST;
        end
        else
        begin
            ctl_reg     <= ctl_next;
            phase_reg   <= phase_next;
            done_st_reg <= done_st_next;
            fin_st_reg  <= fin_st_next;
            fin_has_reg <= fin_has_next;
            last_in_reg <= last_in_next;
            buf_reg     <= buf_next;
            held_reg    <= held_next;
            count_reg   <= count_next;
            len_reg     <= len_next;
            poff_reg    <= poff_next;
            uw_reg      <= uw_next;
            rem_reg     <= rem_next;
            lanes_reg   <= lanes_next;
            full_reg    <= full_next;
            emitted_reg <= emitted_next;
            ov_reg      <= ov_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dist_reg   <= dist_next;
        acc_reg    <= acc_next;
        obytes_reg <= obytes_next;
        ocnt_reg   <= ocnt_next;
        ost_reg    <= ost_next;
        olast_reg  <= olast_next;
    end

    // a nonzero status only rides on the final result of a byte
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && ost_reg != cxlz_pkg::ST_OK |-> olast_reg)
        else $error("status on a result that is not last");

    // never more bytes than lanes in a result
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg |-> ocnt_reg <= 4'(cxlz_pkg::OUT_LANES))
        else $error("byte count beyond lane count");

    // one byte in flight: no new byte right after one is taken
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ch.ready)
        else $error("second byte taken while busy");

endmodule

`default_nettype wire

[tb/cx_lz_bitstream_decompressor_tb.sv]
module cx_lz_bitstream_decompressor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int IDLE_WAIT   = 20;

    // one expected output item
    typedef struct {
        logic [63:0]       out_bytes;
        logic [3:0]        byte_count;
        cxlz_pkg::status_t status;
        logic              last_of_run;
    } out_item_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [16:0] cfg_wdata;

    cxlz_in_if  in_ch();
    cxlz_out_if out_ch();

    cx_lz_bitstream_decompressor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    // decoder copy kept by the testbench
    logic [7:0]        hist_mem [cxlz_pkg::HIST_DEPTH];
    int unsigned       bit_acc;
    int unsigned       bit_cnt;
    cxlz_pkg::phase_t  dec_phase;
    cxlz_pkg::status_t end_status;
    int unsigned       out_total;
    int unsigned       match_len;
    int unsigned       upper_off;
    int unsigned       code_width;
    int unsigned       byte_limit;
    logic [63:0]       lane_acc;
    int unsigned       lane_cnt;
    int unsigned       step_items;

    out_item_t expected_q[$];

    // encoder side: bits still waiting to be packed into bytes
    bit          stream_bits[$];
    int unsigned produced;
    int unsigned bytes_sent;

    int unsigned cycles;
    int unsigned mismatches;
    int unsigned errors;
    bit          quiet;
    bit          hold_req;

    // clock, 8 ns period
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // run watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("cx_lz_bitstream_decompressor_tb: errors");
            $finish;
        end
    end

    // ---------------- prediction ----------------

    function automatic void emit_item(cxlz_pkg::status_t st);
        out_item_t it;
        it.out_bytes   = lane_acc;
        it.byte_count  = 4'(lane_cnt);
        it.status      = st;
        it.last_of_run = 1'b0;
        expected_q.push_back(it);
        step_items++;
        lane_acc = '0;
        lane_cnt = 0;
    endfunction

    function automatic void emit_byte(logic [7:0] b);
        hist_mem[out_total % cxlz_pkg::HIST_DEPTH] = b;
        out_total = (out_total + 1) & 32'h1ffff;
        lane_acc |= 64'(b) << (8 * lane_cnt);
        lane_cnt++;
        if (lane_cnt >= cxlz_pkg::OUT_LANES)
            emit_item(cxlz_pkg::ST_OK);
    endfunction

    function automatic int unsigned pull_bits(int unsigned n);
        int unsigned v;
        v = bit_acc & ((1 << n) - 1);
        bit_acc >>= n;
        bit_cnt -= n;
        return v;
    endfunction

    // walks tokens while bits last; returns a status code or -1
    function automatic int parse_tokens();
        int unsigned b;
        int unsigned n;
        int unsigned off;
        forever
        begin
            case (dec_phase)
                cxlz_pkg::PH_TAG1:
                begin
                    if (bit_cnt < 1) return -1;
                    dec_phase = pull_bits(1) ? cxlz_pkg::PH_TAG2 : cxlz_pkg::PH_LIT;
                end
                cxlz_pkg::PH_LIT:
                begin
                    if (bit_cnt < 8) return -1;
                    b = pull_bits(8);
                    if (out_total >= byte_limit) return int'(cxlz_pkg::ST_OVERFLOW);
                    emit_byte(8'(b));
                    dec_phase = cxlz_pkg::PH_TAG1;
                end
                cxlz_pkg::PH_TAG2:
                begin
                    if (bit_cnt < 1) return -1;
                    upper_off = 0;
                    if (pull_bits(1))
                    begin
                        match_len = 2;
                        dec_phase = cxlz_pkg::PH_OFF_LOW;
                    end
                    else
                    begin
                        code_width = 0;
                        dec_phase  = cxlz_pkg::PH_LEN_UNARY;
                    end
                end
                cxlz_pkg::PH_LEN_UNARY, cxlz_pkg::PH_OFF_UNARY:
                begin
                    if (bit_cnt < 1) return -1;
                    b = pull_bits(1);
                    code_width = (code_width + 1) & 4'hf;
                    if (b)
                        dec_phase = (dec_phase == cxlz_pkg::PH_LEN_UNARY)
                                  ? cxlz_pkg::PH_LEN_VALUE : cxlz_pkg::PH_OFF_VALUE;
                    else if (code_width >= 8)
                        return (dec_phase == cxlz_pkg::PH_LEN_UNARY)
                             ? int'(cxlz_pkg::ST_END) : int'(cxlz_pkg::ST_BAD_OFF);
                end
                cxlz_pkg::PH_LEN_VALUE, cxlz_pkg::PH_OFF_VALUE:
                begin
                    n = code_width;
                    if (n < 1) n = 1;
                    if (n > 8) n = 8;
                    if (bit_cnt < n) return -1;
                    b = ((1 << n) - 1) + pull_bits(n);
                    if (dec_phase == cxlz_pkg::PH_LEN_VALUE)
                    begin
                        b += 2;
                        if (b >= cxlz_pkg::END_LENGTH) return int'(cxlz_pkg::ST_END);
                        match_len = b;
                        dec_phase = cxlz_pkg::PH_EXT_TAG;
                    end
                    else
                    begin
                        upper_off = b;
                        dec_phase = cxlz_pkg::PH_OFF_LOW;
                    end
                end
                cxlz_pkg::PH_EXT_TAG:
                begin
                    if (bit_cnt < 1) return -1;
                    if (pull_bits(1))
                        dec_phase = cxlz_pkg::PH_OFF_LOW;
                    else
                    begin
                        code_width = 0;
                        dec_phase  = cxlz_pkg::PH_OFF_UNARY;
                    end
                end
                cxlz_pkg::PH_OFF_LOW:
                begin
                    if (bit_cnt < 8) return -1;
                    off = upper_off * 256 + pull_bits(8);
                    if (off == 0 || off > out_total || off > cxlz_pkg::HIST_DEPTH)
                        return int'(cxlz_pkg::ST_BAD_OFF);
                    if (out_total + match_len > byte_limit)
                        return int'(cxlz_pkg::ST_OVERFLOW);
                    for (int k = 0; k < match_len; k++)
                        emit_byte(hist_mem[(out_total - off) % cxlz_pkg::HIST_DEPTH]);
                    dec_phase = cxlz_pkg::PH_TAG1;
                end
                default:
                    return int'(cxlz_pkg::ST_TRUNCATED);
            endcase
        end
    endfunction

    // expected output items for one accepted input byte
    function automatic void predict_byte(logic [7:0] b, logic eoi);
        int st;
        lane_acc   = '0;
        lane_cnt   = 0;
        step_items = 0;
        st         = -1;
        if (dec_phase == cxlz_pkg::PH_DONE)
        begin
            // stream over: one empty item repeating the final status
            emit_item(end_status);
        end
        else
        begin
            if (dec_phase == cxlz_pkg::PH_HEADER)
            begin
                if ((b & cxlz_pkg::HDR_MASK) <= cxlz_pkg::HDR_MIN)
                    st = int'(cxlz_pkg::ST_BAD_HDR);
                else
                begin
                    bit_acc   = b >> 3;
                    bit_cnt   = 5;
                    dec_phase = cxlz_pkg::PH_TAG1;
                end
            end
            else
            begin
                bit_acc = (bit_acc | (32'(b) << (bit_cnt & 4'hf))) & 32'hffffff;
                bit_cnt = (bit_cnt + 8) & 5'h1f;
            end
            if (st < 0)
                st = parse_tokens();
            // input ends: clean only on a token boundary with nothing left over
            if (st < 0 && eoi)
                st = (dec_phase == cxlz_pkg::PH_TAG1 && bit_cnt == 0)
                   ? int'(cxlz_pkg::ST_OK) : int'(cxlz_pkg::ST_TRUNCATED);
            if (st >= 0)
            begin
                dec_phase  = cxlz_pkg::PH_DONE;
                end_status = cxlz_pkg::status_t'(st);
                bit_acc    = 0;
                bit_cnt    = 0;
                emit_item(end_status);
            end
            else if (lane_cnt > 0 || step_items == 0)
                emit_item(cxlz_pkg::ST_OK);
        end
        expected_q[$].last_of_run = 1'b1;
    endfunction

    // ---------------- result checker ----------------

    always @(posedge clk)
    begin
        out_item_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_q.size() == 0)
            begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected item: bytes=%h count=%0d status=%0d last=%b",
                             out_ch.out_bytes, out_ch.byte_count, out_ch.status,
                             out_ch.last_of_run);
                mismatches++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (out_ch.out_bytes !== e.out_bytes || out_ch.byte_count !== e.byte_count ||
                    out_ch.status !== e.status || out_ch.last_of_run !== e.last_of_run)
                begin
                    errors++;
                    if (mismatches < 10)
                        $display("mismatch: exp %h/%0d/%0d/%b got %h/%0d/%0d/%b",
                                 e.out_bytes, e.byte_count, e.status, e.last_of_run,
                                 out_ch.out_bytes, out_ch.byte_count, out_ch.status,
                                 out_ch.last_of_run);
                    mismatches++;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    // random stall bursts, plus one long hold-off on request
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ch.ready = 1'b0;
                repeat (400) @(negedge clk);
                hold_req = 1'b0;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
            end
            else
                out_ch.ready = 1'b1;
        end
    end

    // ---------------- sender ----------------

    task automatic send_byte(logic [7:0] b, logic eoi);
        @(negedge clk);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_ch.valid        = 1'b1;
        in_ch.in_byte      = b;
        in_ch.end_of_input = eoi;
        do
            @(posedge clk);
        while (!in_ch.ready);
        bytes_sent++;
        predict_byte(b, eoi);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_ch.valid = 1'b0;
        while (expected_q.size() != 0)
            @(negedge clk);
        // no item can leave the parser busy once its last result is out
        repeat (IDLE_WAIT) @(negedge clk);
    endtask

    task automatic set_limit(int unsigned v);
        @(negedge clk);
        cfg_we     = 1'b1;
        cfg_wdata  = 17'(v);
        byte_limit = v;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // ---------------- stream encoder ----------------

    function automatic void push_bits(int unsigned v, int unsigned n);
        for (int k = 0; k < n; k++)
            stream_bits.push_back(bit'((v >> k) & 1));
    endfunction

    // unary width then value bits, for m >= 1
    function automatic void push_code(int unsigned m);
        int unsigned n;
        n = 1;
        while ((1 << (n + 1)) - 1 <= m)
            n++;
        push_bits(0, n - 1);
        push_bits(1, 1);
        push_bits(m - ((1 << n) - 1), n);
    endfunction

    function automatic void tok_literal(logic [7:0] b);
        push_bits(0, 1);
        push_bits(b, 8);
        produced++;
    endfunction

    function automatic void tok_short(int unsigned off);
        push_bits(3, 2);
        push_bits(off, 8);
        produced += 2;
    endfunction

    function automatic void tok_long(int unsigned len, int unsigned off);
        push_bits(1, 2);
        push_code(len - 2);
        if ((off >> 8) == 0)
            push_bits(1, 1);
        else
        begin
            push_bits(0, 1);
            push_code(off >> 8);
        end
        push_bits(off & 8'hff, 8);
        produced += len;
    endfunction

    // send every whole byte the encoder holds
    task automatic flush_bytes();
        logic [7:0] b;
        while (stream_bits.size() >= 8)
        begin
            for (int k = 0; k < 8; k++)
                b[k] = stream_bits.pop_front();
            send_byte(b, 1'b0);
        end
    endtask

    // one random well-formed token, offsets always within bytes already made
    task automatic random_token();
        int unsigned sel;
        int unsigned top;
        int unsigned len;
        sel = $urandom_range(0, 99);
        top = (produced < cxlz_pkg::HIST_DEPTH) ? produced : cxlz_pkg::HIST_DEPTH;
        if (sel < 40 || produced == 0)
            tok_literal(8'($urandom));
        else if (sel < 65)
            tok_short($urandom_range(1, (top < 255) ? top : 255));
        else
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 257) : $urandom_range(3, 20);
            // favor near offsets, but reach far back too
            if ($urandom_range(0, 1))
                tok_long(len, $urandom_range(1, (top < 16) ? top : 16));
            else
                tok_long(len, $urandom_range(1, top));
        end
        flush_bytes();
    endtask

    // ---------------- tests ----------------

    // header, byte extremes, both match forms, largest length and far offsets
    task automatic test_directed();
        push_bits($urandom_range(4, 7), 3);
        tok_literal(8'h00);
        tok_literal(8'hff);
        tok_literal(8'ha5);
        tok_short(1);
        tok_short(3);
        tok_long(3, 1);
        tok_long(4, 5);
        tok_long(257, 2);
        tok_long(5, produced);
        tok_literal(8'h5a);
        tok_long(9, 260);
        tok_long(17, produced);
        tok_short(255);
        flush_bytes();
        wait_idle();
    endtask

    // output held off while literals keep coming
    task automatic test_backpressure();
        hold_req = 1'b1;
        for (int k = 0; k < 40; k++)
        begin
            tok_literal(8'($urandom));
            flush_bytes();
        end
        wait_idle();
    endtask

    task automatic test_random();
        int unsigned first;
        bit          limit_set;
        first     = bytes_sent;
        limit_set = 1'b0;
        while (bytes_sent - first < 75)
        begin
            random_token();
            if (!limit_set && bytes_sent - first >= 35)
            begin
                limit_set = 1'b1;
                wait_idle();
                set_limit(produced + $urandom_range(4000, 20000));
            end
        end
        wait_idle();
    endtask

    // reach the limit exactly, then one match past it
    task automatic test_limit_edge();
        set_limit(produced + 3);
        tok_short(1);
        tok_literal(8'($urandom));
        tok_long(3, 1);
        while (stream_bits.size() % 8 != 0)
            push_bits($urandom_range(0, 1), 1);
        flush_bytes();
        wait_idle();
        set_limit(0);
    endtask

    // stream over: each byte gives one empty item with the final status
    task automatic test_after_end();
        quiet = 1'b1;
        for (int k = 0; k < 6; k++)
            send_byte(8'($urandom), (k == 5) ? 1'b1 : 1'($urandom_range(0, 1)));
        wait_idle();
    endtask

    initial
    begin
        cycles     = 0;
        mismatches = 0;
        errors     = 0;
        quiet      = 1'b0;
        hold_req   = 1'b0;
        produced   = 0;
        bytes_sent = 0;
        bit_acc    = 0;
        bit_cnt    = 0;
        dec_phase  = cxlz_pkg::PH_HEADER;
        end_status = cxlz_pkg::ST_OK;
        out_total  = 0;
        match_len  = 0;
        upper_off  = 0;
        code_width = 0;
        byte_limit = cxlz_pkg::LIMIT_RST;

        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.in_byte      = '0;
        in_ch.end_of_input = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_limit(cxlz_pkg::LIMIT_RST);
        test_directed();
        test_backpressure();
        test_random();
        test_limit_edge();
        test_after_end();

        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("cx_lz_bitstream_decompressor_tb: clean");
        else
            $display("cx_lz_bitstream_decompressor_tb: errors");
        $finish;
    end

endmodule

[files.f]
hw/rtl/cxlz_pkg.sv
hw/rtl/cxlz_stream_if.sv
hw/rtl/cxlz_ram.sv
hw/rtl/cx_lz_bitstream_decompressor.sv
tb/cx_lz_bitstream_decompressor_tb.sv
